>>> sv/fskg_pkg.sv
// ----------------------------------------------------------------------------
// fskg_pkg
// Shared types, codes and constant functions of the four-tone FSK generator.
// ----------------------------------------------------------------------------
package fskg_pkg;

    localparam int TABLE_BITS_DEF    = 12;
    localparam int FRAME_SYMBOLS_DEF = 162;
    localparam int Q15_FULL          = 32767;
    localparam int SYMBOL_STEP       = 12000;
    localparam int DIVIDEND_W        = 55;
    localparam logic [63:0] HALF_PI_Q62 = 64'h6487ED5110B4611A;

    typedef enum logic [1:0] {
        MODE_LOAD  = 2'd0,
        MODE_PHASE = 2'd1,
        MODE_START = 2'd2,
        MODE_TICK  = 2'd3
    } mode_t;

    typedef enum logic [2:0] {
        CFG_STEP0     = 3'd0,
        CFG_STEP1     = 3'd1,
        CFG_STEP2     = 3'd2,
        CFG_STEP3     = 3'd3,
        CFG_AMPLITUDE = 3'd4,
        CFG_FRAME     = 3'd5,
        CFG_RAMP      = 3'd6,
        CFG_PERIOD    = 3'd7
    } cfg_index_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_AMP,
        ST_AMPDIV,
        ST_DIV,
        ST_ENV,
        ST_OUT
    } back_state_t;

    typedef struct packed {
        mode_t       mode;
        logic        slot_ok;
        logic [7:0]  slot;
        logic [1:0]  tone;
        logic [63:0] phase;
    } item_t;

    typedef struct packed {
        logic [3:0][63:0]   step;
        logic signed [15:0] amplitude;
        logic [39:0]        frame_samples;
        logic [39:0]        ramp_samples;
        logic [45:0]        symbol_period;
    } cfg_t;

    function automatic logic [63:0] mul_q62(input logic [63:0] a, input logic [63:0] b);
        logic [127:0] p;
        p = a * b;
        return p[125:62];
    endfunction

    function automatic logic [63:0] udiv64(input logic [63:0] a, input logic [63:0] b);
        logic [64:0] rem;
        logic [63:0] quo;
        rem = '0;
        quo = '0;
        for (int i = 63; i >= 0; i--)
        begin
            rem = {rem[63:0], a[i]};
            if (rem >= {1'b0, b})
            begin
                rem    = rem - {1'b0, b};
                quo[i] = 1'b1;
            end
        end
        return quo;
    endfunction

    function automatic logic [14:0] quarter_value(input int qs, input int k);
        logic [63:0] low_mask;
        logic [63:0] kk;
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] term;
        logic [63:0] sum;
        logic [63:0] p;
        logic [63:0] r;
        logic [63:0] d;
        low_mask = (64'd1 << qs) - 64'd1;
        kk = 64'(k);
        x = (HALF_PI_Q62 >> qs) * kk + (((HALF_PI_Q62 & low_mask) * kk) >> qs);
        x2 = mul_q62(x, x);
        term = x;
        sum = x;
        for (int n = 1; n <= 12; n++)
        begin
            d = 64'((2 * n) * (2 * n + 1));
            term = udiv64(mul_q62(term, x2), d);
            if ((n & 1) == 1)
                sum = sum - term;
            else
                sum = sum + term;
        end
        p = (sum >> 20) * 64'(Q15_FULL);
        r = (p + (64'd1 << 41)) >> 42;
        if (r > 64'(Q15_FULL))
            r = 64'(Q15_FULL);
        return r[14:0];
    endfunction

    function automatic logic [15:0] div_q15(input logic [30:0] m);
        logic [15:0] t1;
        logic [16:0] r1;
        logic [1:0]  t2;
        logic [15:0] r2;
        t1 = m[30:15];
        r1 = {2'b00, m[14:0]} + {1'b0, t1};
        t2 = r1[16:15];
        r2 = {1'b0, r1[14:0]} + {14'd0, t2};
        return t1 + {14'd0, t2} + {15'd0, (r2 >= 16'(Q15_FULL))};
    endfunction

endpackage

>>> sv/fskg_front.sv
// ----------------------------------------------------------------------------
// fskg_front
// Accepts requests, classifies them and holds them in a two-entry queue.
// ----------------------------------------------------------------------------
module fskg_front #(
    parameter int FRAME_SYMBOLS = fskg_pkg::FRAME_SYMBOLS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  logic [1:0]          mode,
    input  logic [7:0]          symbol_slot,
    input  logic [7:0]          tone_value,
    input  logic [63:0]         phase_value,
    output logic                head_valid,
    output fskg_pkg::item_t     head,
    input  logic                pop
);

    fskg_pkg::item_t q_reg [2];
    logic [1:0] count_reg;
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic       push;
    logic       do_pop;
    fskg_pkg::item_t in_item;

    assign busy       = (count_reg == 2'd2);
    assign head_valid = (count_reg != 2'd0);
    assign head       = q_reg[rd_ptr_reg];
    assign push       = start && !busy;
    assign do_pop     = pop && head_valid;

    always_comb
    begin
        in_item.mode    = fskg_pkg::mode_t'(mode);
        in_item.slot    = symbol_slot;
        in_item.slot_ok = ({1'b0, symbol_slot} < 9'(FRAME_SYMBOLS));
        in_item.tone    = (tone_value > 8'd3) ? 2'd0 : tone_value[1:0];
        in_item.phase   = phase_value;
    end

    always_ff @(posedge clk)
    begin
        if (push)
            q_reg[wr_ptr_reg] <= in_item;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= 2'd0;
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= !wr_ptr_reg;
            if (do_pop)
                rd_ptr_reg <= !rd_ptr_reg;
            count_reg <= count_reg + {1'b0, push} - {1'b0, do_pop};
        end
    end

endmodule

>>> sv/fskg_back.sv
// ----------------------------------------------------------------------------
// fskg_back
// Carries out queued requests: tone store, phase and symbol state, sample
// synthesis with amplitude scaling and ramp envelope.
// ----------------------------------------------------------------------------
module fskg_back #(
    parameter int TABLE_BITS    = fskg_pkg::TABLE_BITS_DEF,
    parameter int FRAME_SYMBOLS = fskg_pkg::FRAME_SYMBOLS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  fskg_pkg::cfg_t      cfg,
    input  logic                head_valid,
    input  fskg_pkg::item_t     head,
    output logic                pop,
    output logic                done,
    output logic signed [15:0]  i_sample,
    output logic signed [15:0]  q_sample,
    output logic [7:0]          symbol_position,
    output logic                last_sample
);

    localparam int QS      = TABLE_BITS - 2;
    localparam int QUARTER = 1 << QS;
    localparam int SW      = (FRAME_SYMBOLS > 1) ? $clog2(FRAME_SYMBOLS) : 1;
    localparam int DIVIDEND_W_L = fskg_pkg::DIVIDEND_W;

    logic [14:0] qw [QUARTER + 1];

    for (genvar g = 0; g <= QUARTER; g++)
    begin : g_qw
        localparam logic [14:0] V = fskg_pkg::quarter_value(QS, g);
        assign qw[g] = V;
    end

    logic [1:0] tone_mem [FRAME_SYMBOLS];

    fskg_pkg::back_state_t state_reg, state_next;

    logic [63:0] phase_reg;
    logic [39:0] count_reg;
    logic [45:0] sacc_reg;
    logic [7:0]  sidx_reg;

    logic [1:0]         tone_reg;
    logic [14:0]        sin_rd_reg, cos_rd_reg;
    logic               sin_neg_reg, cos_neg_reg;
    logic               env_full_reg;
    logic [39:0]        num_reg;
    logic               last_reg;
    logic signed [31:0] ip_reg, qp_reg;
    logic signed [15:0] ci_reg, sq_reg;
    logic [DIVIDEND_W_L-1:0] dvd_reg;
    logic [39:0]        rem_reg;
    logic [15:0]        quo_reg;
    logic [5:0]         dcnt_reg;

    logic [TABLE_BITS-1:0] idx_sin, idx_cos;
    logic [QS:0]           k_sin, k_cos;
    logic                  is_tick, in_frame;
    logic [40:0]           n_plus_ramp;
    logic [40:0]           rem_sh;
    logic                  rem_ge;
    logic [14:0]           env;
    logic [46:0]           acc;
    logic [46:0]           acc_adj;
    logic                  done_reg;
    logic signed [15:0]    i_out_reg, q_out_reg;
    logic [7:0]            pos_reg;
    logic                  last_out_reg;

    function automatic logic signed [15:0] scale(input logic signed [31:0] p, input logic sat);
        logic [30:0] mag;
        logic [15:0] q;
        logic signed [16:0] v;
        mag = p[31] ? 31'(-p) : p[30:0];
        q = fskg_pkg::div_q15(mag);
        if (p[31])
            v = -$signed({1'b0, q});
        else if (sat && q > 16'(fskg_pkg::Q15_FULL))
            v = 17'(fskg_pkg::Q15_FULL);
        else
            v = $signed({1'b0, q});
        return v[15:0];
    endfunction

    assign idx_sin = phase_reg[63 -: TABLE_BITS];
    assign idx_cos = idx_sin + TABLE_BITS'(QUARTER);
    assign k_sin   = idx_sin[QS] ? (QS+1)'(QUARTER) - {1'b0, idx_sin[QS-1:0]}
                                 : {1'b0, idx_sin[QS-1:0]};
    assign k_cos   = idx_cos[QS] ? (QS+1)'(QUARTER) - {1'b0, idx_cos[QS-1:0]}
                                 : {1'b0, idx_cos[QS-1:0]};

    assign is_tick     = head_valid && (head.mode == fskg_pkg::MODE_TICK);
    assign in_frame    = (count_reg < cfg.frame_samples);
    assign n_plus_ramp = {1'b0, count_reg} + {1'b0, cfg.ramp_samples};
    assign rem_sh      = {rem_reg, dvd_reg[DIVIDEND_W_L-1]};
    assign rem_ge      = (rem_sh >= {1'b0, cfg.ramp_samples});
    assign env         = env_full_reg ? 15'(fskg_pkg::Q15_FULL) : quo_reg[14:0];
    assign acc         = {1'b0, sacc_reg} + 47'(fskg_pkg::SYMBOL_STEP);
    assign acc_adj     = acc - {1'b0, cfg.symbol_period};

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            fskg_pkg::ST_IDLE:
                if (is_tick && in_frame)
                    state_next = fskg_pkg::ST_AMP;
            fskg_pkg::ST_AMP:
                state_next = fskg_pkg::ST_AMPDIV;
            fskg_pkg::ST_AMPDIV:
                state_next = env_full_reg ? fskg_pkg::ST_ENV : fskg_pkg::ST_DIV;
            fskg_pkg::ST_DIV:
                if (dcnt_reg == 6'(DIVIDEND_W_L - 1))
                    state_next = fskg_pkg::ST_ENV;
            fskg_pkg::ST_ENV:
                state_next = fskg_pkg::ST_OUT;
            fskg_pkg::ST_OUT:
                state_next = fskg_pkg::ST_IDLE;
            default:
                state_next = fskg_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        pop = 1'b0;
        case (state_reg)
            fskg_pkg::ST_IDLE:
                pop = head_valid;
            default:
                pop = 1'b0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == fskg_pkg::ST_IDLE && head_valid
            && head.mode == fskg_pkg::MODE_LOAD && head.slot_ok)
            tone_mem[head.slot[SW-1:0]] <= head.tone;
        tone_reg <= tone_mem[sidx_reg[SW-1:0]];
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            fskg_pkg::ST_IDLE:
            begin
                sin_rd_reg  <= qw[k_sin];
                cos_rd_reg  <= qw[k_cos];
                sin_neg_reg <= idx_sin[TABLE_BITS-1];
                cos_neg_reg <= idx_cos[TABLE_BITS-1];
                last_reg    <= ({1'b0, count_reg} + 41'd1 == {1'b0, cfg.frame_samples});
                if (cfg.ramp_samples == 40'd0 || cfg.frame_samples == 40'd0)
                begin
                    env_full_reg <= 1'b1;
                    num_reg      <= 40'd0;
                end
                else if (count_reg < cfg.ramp_samples)
                begin
                    env_full_reg <= 1'b0;
                    num_reg      <= count_reg;
                end
                else if (n_plus_ramp >= {1'b0, cfg.frame_samples})
                begin
                    env_full_reg <= 1'b0;
                    num_reg      <= cfg.frame_samples - count_reg;
                end
                else
                begin
                    env_full_reg <= 1'b1;
                    num_reg      <= 40'd0;
                end
            end
            fskg_pkg::ST_AMP:
            begin
                ip_reg  <= (cos_neg_reg ? -$signed({1'b0, cos_rd_reg})
                                        : $signed({1'b0, cos_rd_reg})) * cfg.amplitude;
                qp_reg  <= (sin_neg_reg ? -$signed({1'b0, sin_rd_reg})
                                        : $signed({1'b0, sin_rd_reg})) * cfg.amplitude;
                dvd_reg <= DIVIDEND_W_L'(num_reg) * DIVIDEND_W_L'(fskg_pkg::Q15_FULL);
            end
            fskg_pkg::ST_AMPDIV:
            begin
                ci_reg   <= scale(ip_reg, 1'b1);
                sq_reg   <= scale(qp_reg, 1'b1);
                rem_reg  <= 40'd0;
                quo_reg  <= 16'd0;
                dcnt_reg <= 6'd0;
            end
            fskg_pkg::ST_DIV:
            begin
                rem_reg  <= rem_ge ? 40'(rem_sh - {1'b0, cfg.ramp_samples}) : rem_sh[39:0];
                quo_reg  <= {quo_reg[14:0], rem_ge};
                dvd_reg  <= {dvd_reg[DIVIDEND_W_L-2:0], 1'b0};
                dcnt_reg <= dcnt_reg + 6'd1;
            end
            fskg_pkg::ST_ENV:
            begin
                ip_reg <= ci_reg * $signed({1'b0, env});
                qp_reg <= sq_reg * $signed({1'b0, env});
            end
            fskg_pkg::ST_OUT:
            begin
                i_out_reg    <= scale(ip_reg, 1'b0);
                q_out_reg    <= scale(qp_reg, 1'b0);
                pos_reg      <= sidx_reg;
                last_out_reg <= last_reg;
            end
            default:
            begin
                dcnt_reg <= dcnt_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= fskg_pkg::ST_IDLE;
            phase_reg <= 64'd0;
            count_reg <= 40'd0;
            sacc_reg  <= 46'd0;
            sidx_reg  <= 8'd0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= (state_reg == fskg_pkg::ST_OUT);
            if (state_reg == fskg_pkg::ST_IDLE && head_valid)
            begin
                if (head.mode == fskg_pkg::MODE_PHASE)
                    phase_reg <= head.phase;
                if (head.mode == fskg_pkg::MODE_START)
                begin
                    count_reg <= 40'd0;
                    sacc_reg  <= 46'd0;
                    sidx_reg  <= 8'd0;
                end
            end
            if (state_reg == fskg_pkg::ST_OUT)
            begin
                phase_reg <= phase_reg + cfg.step[tone_reg];
                count_reg <= count_reg + 40'd1;
                if (acc >= {1'b0, cfg.symbol_period})
                begin
                    sacc_reg <= acc_adj[45:0];
                    if ({1'b0, sidx_reg} < 9'(FRAME_SYMBOLS - 1))
                        sidx_reg <= sidx_reg + 8'd1;
                end
                else
                    sacc_reg <= acc[45:0];
            end
        end
    end

    assign done            = done_reg;
    assign i_sample        = i_out_reg;
    assign q_sample        = q_out_reg;
    assign symbol_position = pos_reg;
    assign last_sample     = last_out_reg;

endmodule

>>> sv/fsk_frame_iq_generator_core.sv
// ----------------------------------------------------------------------------
// fsk_frame_iq_generator_core
// Four-tone FSK I/Q generator with amplitude scaling and frame ramp envelope.
// Load, set phase and start requests hold the back end for 1 cycle.
// An in-frame sample tick takes the back end through AMP, AMPDIV, ENV and OUT,
// with DIV (55-step envelope divider) after AMPDIV while the ramp envelope is
// active; the done strobe is registered from the OUT state.
// A two-entry queue accepts requests while the back end works.
// Reset clears control, phase and symbol state; the receiver cannot stall.
// ----------------------------------------------------------------------------
module fsk_frame_iq_generator_core #(
    parameter int TABLE_BITS    = fskg_pkg::TABLE_BITS_DEF,
    parameter int FRAME_SYMBOLS = fskg_pkg::FRAME_SYMBOLS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_write,
    input  logic [2:0]          cfg_index,
    input  logic [63:0]         cfg_data,
    input  logic                start,
    output logic                busy,
    input  logic [1:0]          mode,
    input  logic [7:0]          symbol_slot,
    input  logic [7:0]          tone_value,
    input  logic [63:0]         phase_value,
    output logic                done,
    output logic signed [15:0]  i_sample,
    output logic signed [15:0]  q_sample,
    output logic [7:0]          symbol_position,
    output logic                last_sample
);

    fskg_pkg::cfg_t  cfg_reg;
    fskg_pkg::item_t head;
    logic            head_valid;
    logic            pop;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.step          <= '0;
            cfg_reg.amplitude     <= 16'sd32767;
            cfg_reg.frame_samples <= 40'd0;
            cfg_reg.ramp_samples  <= 40'd0;
            cfg_reg.symbol_period <= 46'd0;
        end
        else if (cfg_write)
        begin
            case (fskg_pkg::cfg_index_t'(cfg_index))
                fskg_pkg::CFG_STEP0:     cfg_reg.step[0]       <= cfg_data;
                fskg_pkg::CFG_STEP1:     cfg_reg.step[1]       <= cfg_data;
                fskg_pkg::CFG_STEP2:     cfg_reg.step[2]       <= cfg_data;
                fskg_pkg::CFG_STEP3:     cfg_reg.step[3]       <= cfg_data;
                fskg_pkg::CFG_AMPLITUDE: cfg_reg.amplitude     <= cfg_data[15:0];
                fskg_pkg::CFG_FRAME:     cfg_reg.frame_samples <= cfg_data[39:0];
                fskg_pkg::CFG_RAMP:      cfg_reg.ramp_samples  <= cfg_data[39:0];
                fskg_pkg::CFG_PERIOD:    cfg_reg.symbol_period <= cfg_data[45:0];
                default:                 cfg_reg.symbol_period <= cfg_reg.symbol_period;
            endcase
        end
    end

    fskg_front #(
        .FRAME_SYMBOLS (FRAME_SYMBOLS)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .mode        (mode),
        .symbol_slot (symbol_slot),
        .tone_value  (tone_value),
        .phase_value (phase_value),
        .head_valid  (head_valid),
        .head        (head),
        .pop         (pop)
    );

    fskg_back #(
        .TABLE_BITS    (TABLE_BITS),
        .FRAME_SYMBOLS (FRAME_SYMBOLS)
    ) u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg             (cfg_reg),
        .head_valid      (head_valid),
        .head            (head),
        .pop             (pop),
        .done            (done),
        .i_sample        (i_sample),
        .q_sample        (q_sample),
        .symbol_position (symbol_position),
        .last_sample     (last_sample)
    );

endmodule

>>> tb/sv/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the four-tone FSK I/Q generator: requests go in on
// the start/busy handshake, every done strobe is compared field by field with
// a bit-true prediction of phase, tone, amplitude, envelope and symbol state.
// ----------------------------------------------------------------------------
module tb;
    import fskg_pkg::*;

    typedef struct {
        logic signed [15:0] i;
        logic signed [15:0] q;
        logic [7:0]         pos;
        logic               last;
    } iq_t;

    class iq_scoreboard;
        logic [63:0]        step [4];
        logic signed [15:0] amp;
        logic [39:0]        frame_len;
        logic [39:0]        ramp_len;
        logic [45:0]        period;
        logic [63:0]        phase;
        logic [39:0]        count;
        logic [45:0]        sym_acc;
        int                 sym_idx;
        logic [1:0]         tones [FRAME_SYMBOLS_DEF];
        int                 quarter [0:1024];
        iq_t                pending_iq [$];
        int                 errors;
        int                 samples;
        int                 frames;

        function new();
            for (int k = 0; k <= 1024; k++)
                quarter[k] = sin_point(k);
            for (int t = 0; t < 4; t++)
                step[t] = '0;
            amp = 16'sd32767;
            frame_len = '0;
            ramp_len = '0;
            period = '0;
            phase = '0;
            count = '0;
            sym_acc = '0;
            sym_idx = 0;
            errors = 0;
            samples = 0;
            frames = 0;
        endfunction

        function logic [63:0] q62(logic [63:0] a, logic [63:0] b);
            logic [127:0] prod;
            prod = {64'd0, a} * {64'd0, b};
            return prod[125:62];
        endfunction

        function int sin_point(int k);
            logic [63:0] x;
            logic [63:0] x2;
            logic [63:0] term;
            logic [63:0] acc;
            logic [63:0] r;
            x = (HALF_PI_Q62 >> 10) * 64'(k) + (((HALF_PI_Q62 & 64'h3FF) * 64'(k)) >> 10);
            x2 = q62(x, x);
            term = x;
            acc = x;
            for (int n = 1; n <= 12; n++)
            begin
                term = q62(term, x2) / 64'((2 * n) * (2 * n + 1));
                if (n % 2 == 1)
                    acc = acc - term;
                else
                    acc = acc + term;
            end
            r = (((acc >> 20) * 64'd32767) + (64'd1 << 41)) >> 42;
            if (r > 64'd32767)
                r = 64'd32767;
            return int'(r);
        endfunction

        function int sin_of(logic [11:0] idx);
            int k;
            k = idx[9:0];
            if (idx[10])
                k = 1024 - k;
            return idx[11] ? -quarter[k] : quarter[k];
        endfunction

        function longint scale_amp(int s);
            longint v;
            v = (longint'(s) * longint'(amp)) / 32767;
            if (v > 32767)
                v = 32767;
            if (v < -32768)
                v = -32768;
            return v;
        endfunction

        function longint env_at(logic [39:0] n);
            longint unsigned nn;
            longint unsigned fl;
            longint unsigned rl;
            nn = n;
            fl = frame_len;
            rl = ramp_len;
            if (rl == 0 || fl == 0)
                return 32767;
            if (nn < rl)
                return longint'((64'd32767 * nn) / rl);
            if (nn + rl >= fl)
                return longint'((64'd32767 * (fl - nn)) / rl);
            return 32767;
        endfunction

        function void set_reg(cfg_index_t idx, logic [63:0] v);
            case (idx)
                CFG_STEP0, CFG_STEP1, CFG_STEP2, CFG_STEP3: step[idx] = v;
                CFG_AMPLITUDE: amp = v[15:0];
                CFG_FRAME: frame_len = v[39:0];
                CFG_RAMP: ramp_len = v[39:0];
                CFG_PERIOD: period = v[45:0];
                default: ;
            endcase
        endfunction

        function void note(mode_t m, logic [7:0] slot, logic [7:0] tone, logic [63:0] ph);
            iq_t e;
            logic [11:0] idx;
            logic [1:0] t;
            longint env;
            logic [46:0] acc;
            case (m)
                MODE_LOAD:
                    if (slot < FRAME_SYMBOLS_DEF)
                        tones[slot] = (tone > 3) ? 2'd0 : tone[1:0];
                MODE_PHASE: phase = ph;
                MODE_START:
                begin
                    count = '0;
                    sym_acc = '0;
                    sym_idx = 0;
                    frames++;
                end
                default:
                    if (count < frame_len)
                    begin
                        t = tones[sym_idx];
                        idx = phase[63:52];
                        env = env_at(count);
                        e.i = 16'((scale_amp(sin_of(idx + 12'd1024)) * env) / 32767);
                        e.q = 16'((scale_amp(sin_of(idx)) * env) / 32767);
                        e.pos = 8'(sym_idx);
                        e.last = (41'(count) + 41'd1 == 41'(frame_len));
                        pending_iq.push_back(e);
                        phase = phase + step[t];
                        count = count + 40'd1;
                        acc = 47'(sym_acc) + 47'd12000;
                        if (acc >= 47'(period))
                        begin
                            acc = acc - 47'(period);
                            if (sym_idx < FRAME_SYMBOLS_DEF - 1)
                                sym_idx++;
                        end
                        sym_acc = acc[45:0];
                    end
            endcase
        endfunction

        task report(string msg);
            $display("MISMATCH at %0t: %s", $realtime, msg);
            errors++;
        endtask

        task check(iq_t got);
            iq_t e;
            if (pending_iq.size() == 0)
            begin
                report($sformatf("unexpected sample i=%0d q=%0d", got.i, got.q));
                return;
            end
            e = pending_iq.pop_front();
            samples++;
            if (got.i !== e.i)
                report($sformatf("i_sample %0d, want %0d", got.i, e.i));
            if (got.q !== e.q)
                report($sformatf("q_sample %0d, want %0d", got.q, e.q));
            if (got.pos !== e.pos)
                report($sformatf("symbol_position %0d, want %0d", got.pos, e.pos));
            if (got.last !== e.last)
                report($sformatf("last_sample %0b, want %0b", got.last, e.last));
        endtask
    endclass

    logic        clk;
    logic        rst_n;
    logic        cfg_write;
    logic [2:0]  cfg_index;
    logic [63:0] cfg_data;
    logic        start;
    logic        busy;
    logic [1:0]  mode;
    logic [7:0]  symbol_slot;
    logic [7:0]  tone_value;
    logic [63:0] phase_value;
    logic        done;
    logic signed [15:0] i_sample;
    logic signed [15:0] q_sample;
    logic [7:0]  symbol_position;
    logic        last_sample;

    iq_scoreboard sb;
    int idle_pct;
    int sent;

    fsk_frame_iq_generator_core u_top (
        .clk(clk), .rst_n(rst_n),
        .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .start(start), .busy(busy),
        .mode(mode), .symbol_slot(symbol_slot), .tone_value(tone_value),
        .phase_value(phase_value),
        .done(done), .i_sample(i_sample), .q_sample(q_sample),
        .symbol_position(symbol_position), .last_sample(last_sample)
    );

    always
    begin
        clk = 1'b1;
        #2;
        clk = 1'b0;
        #2;
    end

    always @(posedge clk)
    begin
        iq_t got;
        if (rst_n && done)
        begin
            got.i = i_sample;
            got.q = q_sample;
            got.pos = symbol_position;
            got.last = last_sample;
            sb.check(got);
        end
    end

    initial
    begin
        #5000000;
        $display("tb NOT OK");
        $finish;
    end

    task idle(int n);
        start <= 1'b0;
        repeat (n) @(negedge clk);
    endtask

    task send(mode_t m, logic [7:0] slot, logic [7:0] tone, logic [63:0] ph);
        while ($urandom_range(99) < idle_pct)
            idle(1);
        start <= 1'b1;
        mode <= m;
        symbol_slot <= slot;
        tone_value <= tone;
        phase_value <= ph;
        do
            @(posedge clk);
        while (busy);
        sb.note(m, slot, tone, ph);
        sent++;
        @(negedge clk);
    endtask

    task tick();
        send(MODE_TICK, 8'($urandom), 8'($urandom), {$urandom, $urandom});
    endtask

    // hold until every sample is back, then let the back end drain
    task drain();
        start <= 1'b0;
        while (sb.pending_iq.size() > 0)
            @(negedge clk);
        repeat (80) @(negedge clk);
    endtask

    task write_reg(cfg_index_t idx, logic [63:0] v);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= v;
        sb.set_reg(idx, v);
        @(negedge clk);
    endtask

    task setup(logic signed [15:0] a, logic [39:0] fl, logic [39:0] rl, logic [45:0] per);
        drain();
        for (int t = 0; t < 4; t++)
            write_reg(cfg_index_t'(t), {$urandom, $urandom});
        write_reg(CFG_AMPLITUDE, 64'(a));
        write_reg(CFG_FRAME, 64'(fl));
        write_reg(CFG_RAMP, 64'(rl));
        write_reg(CFG_PERIOD, 64'(per));
        cfg_write <= 1'b0;
        @(negedge clk);
    endtask

    task random_setup();
        logic signed [15:0] a;
        logic [39:0] fl;
        logic [39:0] rl;
        logic [45:0] per;
        int r;
        r = $urandom_range(9);
        a = (r == 0) ? -16'sd32768 : (r == 1) ? 16'sd32767 : (r == 2) ? 16'sd0 : 16'($urandom);
        r = $urandom_range(19);
        fl = (r == 0) ? 40'd0 : (r < 4) ? 40'($urandom_range(160, 200)) : 40'($urandom_range(1, 60));
        rl = ($urandom_range(2) == 0) ? 40'd0 : 40'($urandom_range(1, int'(fl) + 4));
        r = $urandom_range(3);
        per = (r == 0) ? 46'd0 : (r == 1) ? 46'd12000 : (r == 2) ? 46'($urandom_range(1, 60000))
            : 46'h2000_0000_0000;
        setup(a, fl, rl, per);
    endtask

    task random_run(int n);
        int r;
        int ticks;
        int stop_at;
        stop_at = sent + n;
        while (sent < stop_at)
        begin
            r = $urandom_range(99);
            if (r < 8)
                send(MODE_PHASE, 8'($urandom), 8'($urandom), {$urandom, $urandom});
            else if (r < 14)
                send(MODE_LOAD, 8'($urandom), 8'($urandom), {$urandom, $urandom});
            else if (r < 17)
                send(mode_t'($urandom_range(3)), 8'($urandom), 8'($urandom),
                     {$urandom, $urandom});
            else
            begin
                send(MODE_START, 8'($urandom), 8'($urandom), {$urandom, $urandom});
                ticks = ((sb.frame_len > 220) ? 220 : int'(sb.frame_len)) + $urandom_range(2);
                if ($urandom_range(9) == 0)
                    ticks = $urandom_range(ticks);
                repeat (ticks)
                begin
                    if (sent >= stop_at)
                        break;
                    if ($urandom_range(99) < 3)
                        send(MODE_LOAD, 8'($urandom_range(161)), 8'($urandom),
                             {$urandom, $urandom});
                    tick();
                end
            end
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_write = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        start = 1'b0;
        mode = '0;
        symbol_slot = '0;
        tone_value = '0;
        phase_value = '0;
        idle_pct = 37;
        sent = 0;
        sb = new();
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        setup(-16'sd32768, 40'd6, 40'd0, 46'd0);
        for (int s = 0; s < FRAME_SYMBOLS_DEF; s++)
            send(MODE_LOAD, 8'(s), 8'($urandom), {$urandom, $urandom});

        send(MODE_PHASE, 8'd0, 8'd0, 64'h8000_0000_0000_0000);
        send(MODE_START, 8'd0, 8'd0, 64'd0);
        tick();
        send(MODE_PHASE, 8'd0, 8'd0, 64'hC000_0000_0000_0000);
        tick();
        send(MODE_PHASE, 8'hFF, 8'hFF, 64'hFFFF_FFFF_FFFF_FFFF);
        tick();
        send(MODE_PHASE, 8'd0, 8'd0, 64'd0);
        tick();
        tick();
        tick();
        tick();
        send(MODE_LOAD, 8'hFF, 8'hFF, 64'd0);
        send(MODE_LOAD, 8'd161, 8'd3, 64'd0);
        send(MODE_LOAD, 8'd0, 8'd7, 64'd0);
        setup(16'sd32767, 40'hFF_FFFF_FFFF, 40'hFF_FFFF_FFFF, 46'h2000_0000_0000);
        send(MODE_START, 8'd0, 8'd0, 64'd0);
        repeat (3) tick();
        setup(16'sd0, 40'd0, 40'd0, 46'd12000);
        send(MODE_START, 8'd0, 8'd0, 64'd0);
        repeat (2) tick();

        for (int regime = 0; regime < 3; regime++)
        begin
            idle_pct = (regime == 0) ? 37 : (regime == 1) ? 52 : 0;
            repeat (2)
            begin
                random_setup();
                random_run(80);
            end
        end

        drain();
        $display("Sent %0d requests over %0d frame starts, checked %0d I/Q samples",
                 sent, sb.frames, sb.samples);
        $display("Settings covered amplitude and frame extremes, ramps and symbol periods");
        if (sb.errors == 0 && sb.pending_iq.size() == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end

endmodule

>>> filelist.f
sv/fskg_pkg.sv
sv/fskg_front.sv
sv/fskg_back.sv
sv/fsk_frame_iq_generator_core.sv
tb/sv/tb.sv
